[rtl/core/lpirq_pkg.sv]
// types and constants shared by the light pen latch and interrupt controller
// no dependencies

package lpirq_pkg;

    // operation codes of an input item
    typedef enum logic [2:0] {
        OP_SOURCE = 3'd0,
        OP_ENABLE = 3'd1,
        OP_ACK    = 3'd2,
        OP_PEN    = 3'd3,
        OP_CHECK  = 3'd4,
        OP_FRAME  = 3'd5
    } t_op;

    // configuration register indexes (byte address = 4 * index)
    typedef enum logic [1:0] {
        CFG_SHORT_DELAY = 2'd0,
        CFG_OLD_IRQ     = 2'd1,
        CFG_TOTAL_LINES = 2'd2,
        CFG_LINE_CYCLES = 2'd3
    } t_cfg_idx;

    localparam int unsigned APB_AW = 4;
    localparam int unsigned APB_DW = 32;

    localparam logic [8:0] TOTAL_LINES_RST = 9'd312;
    localparam logic [6:0] LINE_CYCLES_RST = 7'd63;

    // light pen interrupt source bit
    localparam logic [1:0] LP_BIT = 2'd3;

    typedef struct packed {
        logic [2:0] operation;
        logic [1:0] source_index;
        logic [3:0] mask_value;
        logic       pin_level;
        logic       from_port;
        logic [1:0] sub_cycle;
        logic       phase_one;
        logic [8:0] x_position;
        logic [8:0] v_position;
        logic [6:0] cycle_index;
    } t_in_item;

    typedef struct packed {
        logic       irq_out;
        logic [7:0] irq_status;
        logic [7:0] pen_x;
        logic [7:0] pen_y;
    } t_out_item;

endpackage

[rtl/core/light_pen_latch_irq_controller.sv]
// light pen latch and interrupt register of a raster video chip
// depends on lpirq_pkg (item structs, operation and register codes)
// path: input register, one pass of flag logic, result register
// throughput: one item per cycle while the result side does not stall;
// the output register fills while the next item waits
// reset: synchronous active low; clears interrupt and pen state, loads
// configuration defaults; no clearing pass

module light_pen_latch_irq_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // item input
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  lpirq_pkg::t_in_item               i_in_item,
    // result output
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output lpirq_pkg::t_out_item              o_out_item,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lpirq_pkg::APB_AW-1:0]      paddr,
    input  logic [lpirq_pkg::APB_DW-1:0]      pwdata,
    output logic [lpirq_pkg::APB_DW-1:0]      prdata,
    output logic                              pready
);

    import lpirq_pkg::*;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic       r_short_delay;
    logic       r_old_irq;
    logic [8:0] r_total_lines;
    logic [6:0] r_line_cycles;
    logic       cfg_wr;
    t_cfg_idx   cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = t_cfg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_delay <= 1'b1;
            r_old_irq     <= 1'b0;
            r_total_lines <= TOTAL_LINES_RST;
            r_line_cycles <= LINE_CYCLES_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                CFG_SHORT_DELAY: r_short_delay <= pwdata[0];
                CFG_OLD_IRQ:     r_old_irq     <= pwdata[0];
                CFG_TOTAL_LINES: r_total_lines <= pwdata[8:0];
                CFG_LINE_CYCLES: r_line_cycles <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (cfg_idx)
            CFG_SHORT_DELAY: prdata = {31'd0, r_short_delay};
            CFG_OLD_IRQ:     prdata = {31'd0, r_old_irq};
            CFG_TOTAL_LINES: prdata = {23'd0, r_total_lines};
            CFG_LINE_CYCLES: prdata = {25'd0, r_line_cycles};
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // input register and pipeline control
    // ---------------------------------------------------------------
    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    logic      adv;      // input register moves into the result stage
    logic      in_take;  // input transfer

    // the result stage takes a new item whenever its register is free or drains
    assign adv        = r_in_vld & (~r_out_vld | ~i_out_stall);
    assign o_in_stall = r_in_vld & ~adv;
    assign in_take    = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_item;
        end
    end

    // ---------------------------------------------------------------
    // interrupt and light pen state
    // ---------------------------------------------------------------
    // only source bits 0..3 are ever latched; bit 7 always equals
    // any latched source that is enabled, so it is derived, not stored.
    // of the pending bits only the pen source survives the merge.
    logic [3:0] r_latch,   n_latch;
    logic [3:0] r_enable,  n_enable;
    logic       r_pending, n_pending;
    logic       r_trigger, n_trigger;
    logic       r_latched, n_latched;
    logic       r_ph_one,  n_ph_one;
    logic [1:0] r_delay,   n_delay;
    logic [7:0] r_pen_x,   n_pen_x;
    logic [7:0] r_pen_y,   n_pen_y;

    logic       cap_try;   // capture check requested by this item
    logic       cap_ph1;   // phase of that check
    logic       cap_go;
    logic       last_line;
    logic       last_cycle;

    assign last_line  = (r_total_lines != 9'd0) &&
                        (r_in.v_position == r_total_lines - 9'd1);
    assign last_cycle = (r_line_cycles != 7'd0) &&
                        (r_in.cycle_index == r_line_cycles - 7'd1);

    always_comb begin
        n_latch   = r_latch;
        n_enable  = r_enable;
        n_pending = r_pending;
        n_trigger = r_trigger;
        n_latched = r_latched;
        n_ph_one  = r_ph_one;
        n_delay   = r_delay;
        n_pen_x   = r_pen_x;
        n_pen_y   = r_pen_y;
        cap_try   = 1'b0;
        cap_ph1   = 1'b0;

        case (r_in.operation)
            OP_SOURCE: begin
                n_latch[r_in.source_index] = 1'b1;
            end
            OP_ENABLE: begin
                n_enable = r_in.mask_value;
            end
            OP_ACK: begin
                n_latch = r_latch & ~r_in.mask_value;
            end
            OP_PEN: begin
                if (r_in.from_port) begin
                    // port trigger while already armed leaves the state unchanged
                    if (!r_in.pin_level && !r_trigger) begin
                        n_trigger = ~r_latched;
                        n_ph_one  = 1'b0;
                        n_delay   = r_short_delay ? 2'd2 : 2'd1;
                        cap_try   = 1'b1;
                        cap_ph1   = 1'b0;
                    end
                end else if (!r_in.pin_level) begin
                    // early revision raises the pen interrupt at trigger time on cycle zero
                    if (r_old_irq && (r_in.cycle_index == 7'd0)) begin
                        n_latch[LP_BIT] = 1'b1;
                    end
                    n_trigger = ~r_latched;
                    n_ph_one  = ~r_in.sub_cycle[1];
                    n_delay   = {1'b0, r_in.sub_cycle[0]};
                end
            end
            OP_CHECK: begin
                // phase one merges the deferred pen interrupt first
                if (r_in.phase_one) begin
                    n_latch[LP_BIT] = r_latch[LP_BIT] | r_pending;
                    n_pending       = 1'b0;
                end
                cap_try = 1'b1;
                cap_ph1 = r_in.phase_one;
            end
            OP_FRAME: begin
                n_latched = 1'b0;
            end
            default: ;
        endcase

        // one-shot capture, on the armed state as this item leaves it
        cap_go = cap_try & n_trigger & (cap_ph1 == n_ph_one);
        if (cap_go) begin
            n_trigger = 1'b0;
            n_latched = 1'b1;
            // last line of the frame: armed state is used up, nothing stored
            if (!last_line) begin
                n_pen_x = r_in.x_position[8:1] + {6'd0, n_delay};
                if (!cap_ph1 && last_cycle) begin
                    n_pen_y = r_in.v_position[7:0] + 8'd1;
                end else begin
                    n_pen_y = r_in.v_position[7:0];
                end
                if (!r_old_irq) begin
                    if (cap_ph1) begin
                        n_latch[LP_BIT] = 1'b1;
                    end else begin
                        n_pending = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch   <= '0;
            r_enable  <= '0;
            r_pending <= 1'b0;
            r_trigger <= 1'b0;
            r_latched <= 1'b0;
            r_ph_one  <= 1'b0;
            r_delay   <= '0;
            r_pen_x   <= '0;
            r_pen_y   <= '0;
        end else if (adv) begin
            r_latch   <= n_latch;
            r_enable  <= n_enable;
            r_pending <= n_pending;
            r_trigger <= n_trigger;
            r_latched <= n_latched;
            r_ph_one  <= n_ph_one;
            r_delay   <= n_delay;
            r_pen_x   <= n_pen_x;
            r_pen_y   <= n_pen_y;
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    logic irq_any;

    assign irq_any = |(n_latch & n_enable);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.irq_out    <= irq_any;
            r_out.irq_status <= {irq_any, 3'd0, n_latch};
            r_out.pen_x      <= n_pen_x;
            r_out.pen_y      <= n_pen_y;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    // result register always mirrors the live state it was loaded from
    a_status_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.irq_status[3:0] == r_latch) &&
                      (r_out.irq_status[7] == |(r_latch & r_enable)) &&
                      (r_out.pen_x == r_pen_x) && (r_out.pen_y == r_pen_y))
        else $error("result register out of step with state");

    // an armed pen is never already captured in this frame
    a_trigger_not_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trigger |-> !r_latched)
        else $error("pen armed after capture");

    // every item that leaves the input register becomes a result
    a_adv_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_vld)
        else $error("advanced item produced no result");

    // an empty input register never stalls the sender
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |-> !o_in_stall)
        else $error("stall with empty input register");

endmodule

[bench/lpirq_tb_pkg.sv]
// register mirror of the light pen latch and interrupt controller for the bench
// depends on lpirq_pkg (item structs, operation and register codes)

package lpirq_tb_pkg;

    import lpirq_pkg::*;

    // operation codes the block has to ignore
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    localparam int REPORT_LINES = 100;

    class irq_pen_mirror;
        // configuration copy
        logic       short_delay;
        logic       old_irq;
        logic [8:0] total_lines;
        logic [6:0] line_cycles;
        // interrupt and pen state
        logic [7:0] irq_latch;
        logic [7:0] irq_pending;
        logic [3:0] irq_enable;
        logic       pen_pin;
        logic       pen_trigger;
        logic       pen_latched;
        logic       pen_phase_one;
        logic [1:0] pen_delay;
        logic [7:0] pen_x;
        logic [7:0] pen_y;
        // register images still to come out of the block, oldest first
        t_out_item  regs_due[$];
        int         errors;
        int         checked;
        int         captures;

        function new();
            short_delay   = 1'b1;
            old_irq       = 1'b0;
            total_lines   = TOTAL_LINES_RST;
            line_cycles   = LINE_CYCLES_RST;
            irq_latch     = '0;
            irq_pending   = '0;
            irq_enable    = '0;
            pen_pin       = 1'b1;
            pen_trigger   = 1'b0;
            pen_latched   = 1'b0;
            pen_phase_one = 1'b0;
            pen_delay     = '0;
            pen_x         = '0;
            pen_y         = '0;
            errors        = 0;
            checked       = 0;
            captures      = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [31:0] val);
            case (idx)
                CFG_SHORT_DELAY: short_delay = val[0];
                CFG_OLD_IRQ:     old_irq = val[0];
                CFG_TOTAL_LINES: total_lines = val[8:0];
                CFG_LINE_CYCLES: line_cycles = val[6:0];
                default: ;
            endcase
        endfunction

        // bit 7: any latched source that is enabled
        function void update_any();
            irq_latch[7] = |(irq_latch[3:0] & irq_enable);
        endfunction

        function void raise_source(logic [1:0] src);
            irq_latch[{1'b0, src}] = 1'b1;
            update_any();
        endfunction

        function void try_capture(logic ph1, t_in_item it);
            if (!pen_trigger || ph1 != pen_phase_one)
                return;
            pen_trigger = 1'b0;
            pen_latched = 1'b1;
            // last line of the frame never stores a position
            if (total_lines != 0 && it.v_position == total_lines - 9'd1)
                return;
            pen_x = it.x_position[8:1] + {6'd0, pen_delay};
            if (!ph1 && line_cycles != 0 && it.cycle_index == line_cycles - 7'd1)
                pen_y = it.v_position[7:0] + 8'd1;
            else
                pen_y = it.v_position[7:0];
            captures++;
            if (old_irq)
                return;
            if (ph1)
                raise_source(2'(LP_BIT));
            else
                irq_pending = irq_pending | 8'h80 | (8'h1 << LP_BIT);
        endfunction

        function void take_item(t_in_item it);
            t_out_item regs;
            case (it.operation)
                OP_SOURCE: raise_source(it.source_index);
                OP_ENABLE: begin
                    irq_enable = it.mask_value;
                    update_any();
                end
                OP_ACK: begin
                    irq_latch[3:0] = irq_latch[3:0] & ~it.mask_value;
                    update_any();
                end
                OP_PEN: begin
                    pen_pin = it.pin_level;
                    if (it.from_port) begin
                        if (!it.pin_level && !pen_trigger) begin
                            pen_trigger   = !pen_latched;
                            pen_phase_one = 1'b0;
                            pen_delay     = short_delay ? 2'd2 : 2'd1;
                            try_capture(1'b0, it);
                        end
                    end else if (!it.pin_level) begin
                        if (old_irq && it.cycle_index == 0)
                            raise_source(2'(LP_BIT));
                        pen_trigger   = !pen_latched;
                        pen_phase_one = !it.sub_cycle[1];
                        pen_delay     = {1'b0, it.sub_cycle[0]};
                    end
                end
                OP_CHECK: begin
                    if (it.phase_one) begin
                        irq_latch   = irq_latch | irq_pending;
                        irq_pending = '0;
                        update_any();
                    end
                    try_capture(it.phase_one, it);
                end
                OP_FRAME: pen_latched = 1'b0;
                default: ;
            endcase
            regs.irq_out    = irq_latch[7];
            regs.irq_status = irq_latch;
            regs.pen_x      = pen_x;
            regs.pen_y      = pen_y;
            regs_due.push_back(regs);
        endfunction

        task report(string what);
            if (errors < REPORT_LINES)
                $display("mismatch: %s", what);
            errors++;
        endtask

        task match_regs(t_out_item got);
            t_out_item want;
            if (regs_due.size() == 0) begin
                report($sformatf("result %h with nothing outstanding", got));
                return;
            end
            want = regs_due.pop_front();
            checked++;
            if (got.irq_out !== want.irq_out)
                report($sformatf("result %0d irq_out %b, want %b",
                                 checked, got.irq_out, want.irq_out));
            if (got.irq_status !== want.irq_status)
                report($sformatf("result %0d irq_status %h, want %h",
                                 checked, got.irq_status, want.irq_status));
            if (got.pen_x !== want.pen_x)
                report($sformatf("result %0d pen_x %h, want %h",
                                 checked, got.pen_x, want.pen_x));
            if (got.pen_y !== want.pen_y)
                report($sformatf("result %0d pen_y %h, want %h",
                                 checked, got.pen_y, want.pen_y));
        endtask
    endclass

endpackage

[bench/light_pen_latch_irq_controller_tb.sv]
// bench top for the light pen latch and interrupt controller
// depends on lpirq_pkg and lpirq_tb_pkg (register mirror)

module light_pen_latch_irq_controller_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lpirq_pkg::*;
    import lpirq_tb_pkg::*;

    // longest legal quiet stretch comes from a sender gap, a receiver stall,
    // the pipeline latency and a register write plus readback; the limit takes
    // it many times over
    localparam int IDLE_LIMIT = 4000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    t_in_item            i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_item           o_out_item;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    irq_pen_mirror mirror;
    bit  calm = 1'b0;        // no idling on either side once set
    int  items_sent = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    int  settings_run = 0;

    light_pen_latch_irq_controller dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver back-pressure: stall bursts of random length, one update
    // per falling edge
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // result monitor and watchdog; values read here are the ones from just
    // before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                mirror.match_regs(o_out_item);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("light_pen_latch_irq_controller_tb: done, errors");
                $finish;
            end
        end
    end

    // one input transfer; starts and ends just after a falling edge
    task automatic send_item(t_in_item it);
        if (!calm && $urandom_range(0, 4) == 0) begin
            // sender idles for a burst, valid low
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        mirror.take_item(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    // sender stops and waits for every outstanding result, then lets the
    // pipeline settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (mirror.regs_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // register write (setup + access), then a readback of the same register
    task automatic cfg_set(t_cfg_idx idx, logic [31:0] val);
        logic [31:0] keep;
        logic [31:0] seen;
        keep = (idx == CFG_TOTAL_LINES) ? 32'h1ff :
               (idx == CFG_LINE_CYCLES) ? 32'h7f : 32'h1;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val & keep;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        mirror.set_reg(idx, val & keep);
        // back-to-back read: psel stays high, new setup phase
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        seen = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if ((seen & keep) !== (val & keep))
            mirror.report($sformatf("register %0d reads %h, want %h",
                                    idx, seen & keep, val & keep));
    endtask

    // full register setting; only called with nothing outstanding
    task automatic apply_setting(logic short_sel, logic old_sel,
                                 logic [8:0] lines, logic [6:0] cycles);
        cfg_set(CFG_SHORT_DELAY, 32'(short_sel));
        cfg_set(CFG_OLD_IRQ, 32'(old_sel));
        cfg_set(CFG_TOTAL_LINES, 32'(lines));
        cfg_set(CFG_LINE_CYCLES, 32'(cycles));
        settings_run++;
    endtask

    function automatic t_in_item plain(logic [2:0] op);
        t_in_item it;
        it = '0;
        it.operation = op;
        it.pin_level = 1'b1;
        return it;
    endfunction

    // random item; the beam position leans toward the last line, the last
    // cycle and cycle zero so the corner cases come up often
    function automatic t_in_item random_item();
        t_in_item it;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            it.operation = OP_SOURCE;
        else if (pick < 20)
            it.operation = OP_ENABLE;
        else if (pick < 30)
            it.operation = OP_ACK;
        else if (pick < 48)
            it.operation = OP_PEN;
        else if (pick < 82)
            it.operation = OP_CHECK;
        else if (pick < 96)
            it.operation = OP_FRAME;
        else
            it.operation = ($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B;
        it.source_index = 2'($urandom_range(0, 3));
        it.mask_value   = 4'($urandom_range(0, 15));
        it.pin_level    = 1'($urandom_range(0, 1));
        it.from_port    = 1'($urandom_range(0, 1));
        it.sub_cycle    = 2'($urandom_range(0, 3));
        it.phase_one    = 1'($urandom_range(0, 1));
        it.x_position   = 9'($urandom_range(0, 511));
        it.v_position   = ($urandom_range(0, 3) == 0) ? mirror.total_lines - 9'd1
                                                      : 9'($urandom_range(0, 311));
        pick = $urandom_range(0, 7);
        it.cycle_index  = (pick < 2)  ? mirror.line_cycles - 7'd1 :
                          (pick == 2) ? 7'd0 : 7'($urandom_range(0, 64));
        return it;
    endfunction

    // well-formed capture: new frame, pin released, pin pressed, then one to
    // three half-cycle checks with random phase and beam position
    task automatic pen_sequence();
        t_in_item it;
        int checks;
        it = random_item();
        it.operation = OP_FRAME;
        send_item(it);
        it = random_item();
        it.operation = OP_PEN;
        it.pin_level = 1'b1;
        send_item(it);
        it = random_item();
        it.operation = OP_PEN;
        it.pin_level = 1'b0;
        send_item(it);
        checks = $urandom_range(1, 3);
        repeat (checks) begin
            it = random_item();
            it.operation = OP_CHECK;
            send_item(it);
        end
    endtask

    // about a third of the time a capture sequence, otherwise loose items
    task automatic run_random(int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 2) == 0)
                pen_sequence();
            else
                send_item(random_item());
        end
    endtask

    initial begin
        t_in_item it;
        mirror = new();

        // reset held low from the start, released on a falling edge
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed part, reset configuration ----
        // every source bit, with field extremes on unused fields
        it = plain(OP_SOURCE);
        send_item(it);
        it = plain(OP_SOURCE);
        it.source_index = 2'd1;
        it.x_position   = 9'd511;
        it.v_position   = 9'd311;
        it.cycle_index  = 7'd64;
        it.mask_value   = 4'hf;
        send_item(it);
        it = plain(OP_SOURCE);
        it.source_index = 2'd2;
        send_item(it);
        it = plain(OP_SOURCE);
        it.source_index = 2'd3;
        send_item(it);
        // enable all, partial and full acknowledge, disable
        it = plain(OP_ENABLE);
        it.mask_value = 4'hf;
        send_item(it);
        it = plain(OP_ACK);
        it.mask_value = 4'h5;
        send_item(it);
        it = plain(OP_ACK);
        it.mask_value = 4'hf;
        send_item(it);
        it = plain(OP_ENABLE);
        send_item(it);
        // port trigger latches at once; x wraps past 255
        it = plain(OP_PEN);
        it.from_port  = 1'b1;
        it.pin_level  = 1'b0;
        it.x_position = 9'd511;
        it.v_position = 9'd100;
        it.cycle_index = 7'd10;
        send_item(it);
        // phase-one check merges the deferred pen interrupt
        it = plain(OP_CHECK);
        it.phase_one = 1'b1;
        send_item(it);
        it = plain(OP_ENABLE);
        it.mask_value = 4'h8;
        send_item(it);
        // release, then press again while already latched this frame
        it = plain(OP_PEN);
        it.from_port = 1'b1;
        send_item(it);
        it = plain(OP_PEN);
        it.from_port = 1'b0;
        it.pin_level = 1'b0;
        it.from_port = 1'b1;
        send_item(it);
        // new frame, arm for phase two with delay 1
        send_item(plain(OP_FRAME));
        it = plain(OP_PEN);
        it.pin_level = 1'b0;
        it.sub_cycle = 2'd3;
        send_item(it);
        // port trigger while armed only records the pin
        it = plain(OP_PEN);
        it.from_port = 1'b1;
        it.pin_level = 1'b0;
        it.x_position = 9'd40;
        send_item(it);
        // wrong phase, then phase-two capture on the last cycle of a line
        it = plain(OP_CHECK);
        it.phase_one = 1'b1;
        send_item(it);
        it = plain(OP_CHECK);
        it.x_position  = 9'd300;
        it.v_position  = 9'd200;
        it.cycle_index = 7'd62;
        send_item(it);
        it = plain(OP_CHECK);
        it.phase_one = 1'b1;
        send_item(it);
        // capture on the last line latches but stores nothing
        send_item(plain(OP_FRAME));
        it = plain(OP_PEN);
        it.pin_level = 1'b0;
        send_item(it);
        it = plain(OP_CHECK);
        it.phase_one  = 1'b1;
        it.v_position = 9'd311;
        it.x_position = 9'd77;
        send_item(it);
        // unused operation codes change nothing
        send_item(plain(OP_SPARE_A));
        send_item(plain(OP_SPARE_B));
        it = plain(OP_ACK);
        it.mask_value = 4'hf;
        send_item(it);
        drain();

        // ---- random part over several register settings ----
        // long delay model off, longest lines; sender holds off midway
        apply_setting(1'b0, 1'b0, 9'd312, 7'd65);
        run_random(120);
        drain();
        run_random(100);
        drain();

        // lowest extremes with old irq mode: line zero and cycle zero are the last ones
        apply_setting(1'b1, 1'b1, 9'd1, 7'd1);
        run_random(150);
        drain();

        apply_setting(1'b0, 1'b1, 9'($urandom_range(1, 312)), 7'($urandom_range(1, 65)));
        run_random(150);
        drain();

        apply_setting(1'b1, 1'b0, 9'($urandom_range(1, 312)), 7'($urandom_range(1, 65)));
        run_random(100);
        drain();

        // closing stretch at full rate, back to reset values
        calm = 1'b1;
        apply_setting(1'b1, 1'b0, TOTAL_LINES_RST, LINE_CYCLES_RST);
        run_random(200);
        drain();

        // catch any stray result
        repeat (8) @(posedge i_clk);

        $display("light_pen_latch_irq_controller_tb: %0d items over %0d register settings,",
                 items_sent, settings_run + 1);
        $display("  %0d results compared, %0d pen positions captured, %0d mismatches",
                 mirror.checked, mirror.captures, mirror.errors);
        if (mirror.errors == 0 && mirror.regs_due.size() == 0)
            $display("light_pen_latch_irq_controller_tb: done, clean");
        else
            $display("light_pen_latch_irq_controller_tb: done, errors");
        $finish;
    end

endmodule
